FILE: hdl/stuffed_crc_frame_encoder_unit_assert.svh
// Assertion macros shared by the frame encoder modules.
`ifndef STUFFED_CRC_FRAME_ENCODER_UNIT_ASSERT_SVH
`define STUFFED_CRC_FRAME_ENCODER_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Check prop at every rising clock edge outside reset.
`define SFE_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("frame encoder check failed");
// Check that post holds in the cycle after pre.
`define SFE_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("frame encoder sequence check failed");
`else
`define SFE_ASSERT(label, clk, rst, prop)
`define SFE_ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

FILE: hdl/sfe_pkg.sv
package sfe_pkg;

   // Request kinds
   localparam logic KIND_START = 1'b0;
   localparam logic KIND_DATA  = 1'b1;

   // Wire codes
   localparam logic [7:0] MARK_BYTE  = 8'hC0;
   localparam logic [7:0] ESC_BYTE   = 8'hDB;
   localparam logic [7:0] ESC_MARK   = 8'hDC;
   localparam logic [7:0] ESC_ESC    = 8'hDD;
   localparam logic [7:0] BOARD_FLAG = 8'h80;
   localparam logic [7:0] LEN_HI_MSK = 8'h7F;

   // CRC-16 settings
   localparam logic [15:0] CRC_POLY   = 16'h8005;
   localparam logic [15:0] CRC_INIT   = 16'hFFFF;
   localparam logic [15:0] CRC_XOROUT = 16'hFFFF;

   localparam int QUEUE_DEPTH = 4;

   typedef struct packed {
      logic        kind;
      logic [6:0]  board;
      logic [7:0]  element;
      logic [7:0]  command;
      logic [14:0] length;
      logic [7:0]  data_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       frame_end;
   } rsp_type;

   // One classified request on its way to the back end
   typedef struct packed {
      req_type req;
      logic    closes;
   } desc_type;

   // Advance the CRC over one byte, MSB first
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

FILE: hdl/sfe_front.sv
module sfe_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  sfe_pkg::req_type  req_data,
   output logic              req_stall,
   input  logic              q_full,
   output logic              q_push,
   output sfe_pkg::desc_type q_desc
);

   logic        frame_open_ff, frame_open_in;
   logic [14:0] bytes_left_ff, bytes_left_in;
   logic        accept;
   logic        keep;
   logic        closes;

   // Classify the request and track the open frame
   always_comb begin
      accept        = req_valid && !q_full;
      keep          = 1'b0;
      closes        = 1'b0;
      frame_open_in = frame_open_ff;
      bytes_left_in = bytes_left_ff;
      if (req_data.kind == sfe_pkg::KIND_START) begin
         keep   = 1'b1;
         closes = (req_data.length == 15'd0);
         if (accept) begin
            frame_open_in = !closes;
            bytes_left_in = closes ? 15'd0 : req_data.length;
         end
      end else begin
         keep   = frame_open_ff;
         closes = (bytes_left_ff == 15'd1);
         if (accept && frame_open_ff) begin
            frame_open_in = !closes;
            bytes_left_in = bytes_left_ff - 15'd1;
         end
      end
   end

   assign req_stall     = q_full;
   assign q_push        = accept && keep;
   assign q_desc.req    = req_data;
   assign q_desc.closes = closes;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_open_ff <= 1'b0;
         bytes_left_ff <= 15'd0;
      end else begin
         frame_open_ff <= frame_open_in;
         bytes_left_ff <= bytes_left_in;
      end
   end

endmodule

FILE: hdl/sfe_queue.sv
`include "stuffed_crc_frame_encoder_unit_assert.svh"
module sfe_queue #(
   parameter int DEPTH = sfe_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  sfe_pkg::desc_type push_desc,
   output logic              full,
   output logic              head_valid,
   output sfe_pkg::desc_type head_desc,
   input  logic              pop
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   sfe_pkg::desc_type entries_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_desc  = entries_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_desc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `SFE_ASSERT(a_q_push_room, clock, reset, push |-> !full)
   `SFE_ASSERT(a_q_pop_data, clock, reset, pop |-> head_valid)
   `SFE_ASSERT_NEXT(a_q_count_up, clock, reset, push && !pop, count_ff == $past(count_ff) + 1'b1)

endmodule

FILE: hdl/sfe_back.sv
`include "stuffed_crc_frame_encoder_unit_assert.svh"
module sfe_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  sfe_pkg::desc_type head_desc,
   output logic              pop,
   output logic              rsp_valid,
   output sfe_pkg::rsp_type  rsp_data,
   input  logic              rsp_stall
);

   typedef enum logic [9:0] {
      ST_IDLE  = 10'b0000000001,
      ST_MARK  = 10'b0000000010,
      ST_BOARD = 10'b0000000100,
      ST_ELEM  = 10'b0000001000,
      ST_CMD   = 10'b0000010000,
      ST_LENH  = 10'b0000100000,
      ST_LENL  = 10'b0001000000,
      ST_DATA  = 10'b0010000000,
      ST_CRCH  = 10'b0100000000,
      ST_CRCL  = 10'b1000000000
   } state_type;

   state_type         state_ff, state_in;
   sfe_pkg::desc_type desc_ff, desc_in;
   logic [15:0]       crc_ff, crc_in;
   logic              esc_ff, esc_in;
   logic [7:0]        esc_byte_ff, esc_byte_in;
   logic              rsp_valid_ff, rsp_valid_in;
   sfe_pkg::rsp_type  rsp_data_ff, rsp_data_in;

   logic        out_free;
   logic [15:0] crc_fin;
   logic [7:0]  raw;
   state_type   next_state;
   logic        last_raw;
   logic        feeds_crc;
   logic        need_stuff;
   logic        advance;
   logic        load_next;

   // Pick the unstuffed byte and the step after it
   always_comb begin
      crc_fin    = crc_ff ^ sfe_pkg::CRC_XOROUT;
      raw        = 8'h00;
      next_state = ST_IDLE;
      last_raw   = 1'b0;
      feeds_crc  = 1'b1;
      case (state_ff)
         ST_MARK: begin
            raw        = sfe_pkg::MARK_BYTE;
            next_state = ST_BOARD;
            feeds_crc  = 1'b0;
         end
         ST_BOARD: begin
            raw        = {1'b0, desc_ff.req.board} | sfe_pkg::BOARD_FLAG;
            next_state = ST_ELEM;
         end
         ST_ELEM: begin
            raw        = desc_ff.req.element;
            next_state = ST_CMD;
         end
         ST_CMD: begin
            raw        = desc_ff.req.command;
            next_state = ST_LENH;
         end
         ST_LENH: begin
            raw        = {1'b0, desc_ff.req.length[14:8]} & sfe_pkg::LEN_HI_MSK;
            next_state = ST_LENL;
         end
         ST_LENL: begin
            raw        = desc_ff.req.length[7:0];
            next_state = ST_CRCH;
            last_raw   = !desc_ff.closes;
         end
         ST_DATA: begin
            raw        = desc_ff.req.data_byte;
            next_state = ST_CRCH;
            last_raw   = !desc_ff.closes;
         end
         ST_CRCH: begin
            raw        = crc_fin[15:8];
            next_state = ST_CRCL;
            feeds_crc  = 1'b0;
         end
         ST_CRCL: begin
            raw       = crc_fin[7:0];
            last_raw  = 1'b1;
            feeds_crc = 1'b0;
         end
         default: begin
            feeds_crc = 1'b0;
         end
      endcase
      need_stuff = (state_ff != ST_MARK) &&
                   ((raw == sfe_pkg::MARK_BYTE) || (raw == sfe_pkg::ESC_BYTE));
   end

   // Emit one wire byte per free output slot and load the next request
   always_comb begin
      out_free     = !rsp_valid_ff || !rsp_stall;
      state_in     = state_ff;
      desc_in      = desc_ff;
      crc_in       = crc_ff;
      esc_in       = esc_ff;
      esc_byte_in  = esc_byte_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      advance      = 1'b0;
      load_next    = (state_ff == ST_IDLE);
      pop          = 1'b0;

      if ((state_ff != ST_IDLE) && out_free) begin
         rsp_valid_in = 1'b1;
         if (esc_ff) begin
            rsp_data_in.out_byte = esc_byte_ff;
            esc_in               = 1'b0;
            advance              = 1'b1;
         end else if (need_stuff) begin
            rsp_data_in.out_byte = sfe_pkg::ESC_BYTE;
            esc_in               = 1'b1;
            esc_byte_in          = (raw == sfe_pkg::MARK_BYTE) ? sfe_pkg::ESC_MARK
                                                               : sfe_pkg::ESC_ESC;
         end else begin
            rsp_data_in.out_byte = raw;
            advance              = 1'b1;
         end
         rsp_data_in.run_last  = advance && last_raw;
         rsp_data_in.frame_end = advance && (state_ff == ST_CRCL);
         if (advance) begin
            if (feeds_crc) begin
               crc_in = sfe_pkg::crc_byte(crc_ff, raw);
            end
            if (last_raw) begin
               load_next = 1'b1;
            end else begin
               state_in = next_state;
            end
         end
      end

      if (load_next) begin
         if (head_valid) begin
            pop     = 1'b1;
            desc_in = head_desc;
            if (head_desc.req.kind == sfe_pkg::KIND_START) begin
               state_in = ST_MARK;
               crc_in   = sfe_pkg::CRC_INIT;
            end else begin
               state_in = ST_DATA;
            end
         end else begin
            state_in = ST_IDLE;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      desc_ff     <= desc_in;
      esc_byte_ff <= esc_byte_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         crc_ff       <= sfe_pkg::CRC_INIT;
         esc_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         crc_ff       <= crc_in;
         esc_ff       <= esc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `SFE_ASSERT(a_esc_after_db, clock, reset, esc_ff |-> rsp_data_ff.out_byte == sfe_pkg::ESC_BYTE)
   `SFE_ASSERT(a_end_is_last, clock, reset, rsp_valid_ff && rsp_data_ff.frame_end |-> rsp_data_ff.run_last)
   `SFE_ASSERT(a_idle_no_esc, clock, reset, state_ff == ST_IDLE |-> !esc_ff)

endmodule

FILE: hdl/stuffed_crc_frame_encoder_unit.sv
// Byte-stuffed serial frame encoder with CRC-16 (poly 0x8005, init/xorout 0xFFFF).
// Request channel (req_valid/req_stall/req_data): a start request emits the mark
// byte and five stuffed header bytes; a data request emits one stuffed payload
// byte. The CRC pair follows the last payload byte, or the header at length zero.
// Data requests with no open frame are dropped; a start abandons an open frame.
// Response channel (rsp_valid/rsp_stall/rsp_data): one wire byte per transfer,
// run_last marks the last byte of a request, frame_end the final CRC byte.
// The front end classifies requests into a small queue; the back end expands each
// into wire bytes and stuffs them, one byte per cycle from its output register
// while the response is not stalled. With the back end idle, an accepted request
// passes the queue entry and the back-end state before its first byte is output.
// Bytes per request: 1 or 2 for data, up to 4 more with CRC, 6 to 14 for a start.
// A stalled response holds its byte; requests keep entering until the queue fills.
// Reset clears the queue, the open frame and any pending output.
module stuffed_crc_frame_encoder_unit #(
   parameter int QUEUE_DEPTH = sfe_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  sfe_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output sfe_pkg::rsp_type rsp_data
);

   logic              q_full;
   logic              q_push;
   sfe_pkg::desc_type q_desc;
   logic              head_valid;
   sfe_pkg::desc_type head_desc;
   logic              q_pop;

   sfe_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_desc    (q_desc)
   );

   sfe_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_desc  (q_desc),
      .full       (q_full),
      .head_valid (head_valid),
      .head_desc  (head_desc),
      .pop        (q_pop)
   );

   sfe_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_desc  (head_desc),
      .pop        (q_pop),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data),
      .rsp_stall  (rsp_stall)
   );

endmodule

FILE: sim/stuffed_crc_frame_encoder_unit_tb.sv
module stuffed_crc_frame_encoder_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sfe_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 40;
   localparam int HOLD_OFF_LEN   = 300;
   localparam int HOLD_OFF_AT    = 200;
   localparam int RANDOM_ITEMS   = 225;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // Requests waiting to be offered, wire bytes still due from the block
   req_type req_backlog[$];
   rsp_type wire_bytes_due[$];
   rsp_type burst_bytes[$];

   // Encoder state as predicted
   logic [15:0] crc_run      = CRC_INIT;
   logic [14:0] payload_left = '0;
   logic        frame_live   = 1'b0;

   int mismatch_count = 0;
   int rsp_seen       = 0;
   int quiet_cycles   = 0;

   stuffed_crc_frame_encoder_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #6 clock = ~clock;

   // CRC-16, one message bit at a time, MSB first
   function automatic logic [15:0] crc_shift(input logic [15:0] seed, input logic [7:0] b);
      logic [15:0] acc;
      logic        fb;
      acc = seed;
      for (int k = 7; k >= 0; k--) begin
         fb  = acc[15] ^ b[k];
         acc = {acc[14:0], 1'b0};
         if (fb) begin
            acc = acc ^ CRC_POLY;
         end
      end
      return acc;
   endfunction

   // Mostly short gaps, a few long ones
   function automatic int idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) begin
         return $urandom_range(1, 2);
      end else if (r < 93) begin
         return $urandom_range(3, 6);
      end
      return $urandom_range(10, 30);
   endfunction

   // Favor the two bytes that need escaping
   function automatic logic [7:0] wire_pick();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) begin
         return MARK_BYTE;
      end else if (r == 1) begin
         return ESC_BYTE;
      end
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic req_type make_start(input logic [6:0] board, input logic [7:0] element,
                                          input logic [7:0] command, input logic [14:0] length);
      req_type r;
      r.kind      = KIND_START;
      r.board     = board;
      r.element   = element;
      r.command   = command;
      r.length    = length;
      r.data_byte = 8'($urandom_range(0, 255));
      return r;
   endfunction

   // Header fields of a data request are don't-care, so randomize them
   function automatic req_type make_data(input logic [7:0] b);
      req_type r;
      r.kind      = KIND_DATA;
      r.board     = 7'($urandom_range(0, 127));
      r.element   = 8'($urandom_range(0, 255));
      r.command   = 8'($urandom_range(0, 255));
      r.length    = 15'($urandom_range(0, 32767));
      r.data_byte = b;
      return r;
   endfunction

   // Append one wire byte, escaping mark and escape codes
   task automatic stuff_byte(input logic [7:0] b);
      if (b == MARK_BYTE) begin
         burst_bytes.push_back(rsp_type'{out_byte: ESC_BYTE, run_last: 1'b0, frame_end: 1'b0});
         burst_bytes.push_back(rsp_type'{out_byte: ESC_MARK, run_last: 1'b0, frame_end: 1'b0});
      end else if (b == ESC_BYTE) begin
         burst_bytes.push_back(rsp_type'{out_byte: ESC_BYTE, run_last: 1'b0, frame_end: 1'b0});
         burst_bytes.push_back(rsp_type'{out_byte: ESC_ESC, run_last: 1'b0, frame_end: 1'b0});
      end else begin
         burst_bytes.push_back(rsp_type'{out_byte: b, run_last: 1'b0, frame_end: 1'b0});
      end
   endtask

   task automatic carry_byte(input logic [7:0] b);
      stuff_byte(b);
      crc_run = crc_shift(crc_run, b);
   endtask

   // Send the inverted CRC and close the frame
   task automatic close_frame();
      logic [15:0] fin;
      rsp_type     tail;
      fin = crc_run ^ CRC_XOROUT;
      stuff_byte(fin[15:8]);
      stuff_byte(fin[7:0]);
      tail = burst_bytes.pop_back();
      tail.frame_end = 1'b1;
      burst_bytes.push_back(tail);
      crc_run      = CRC_INIT;
      payload_left = '0;
      frame_live   = 1'b0;
   endtask

   // Work out the wire bytes one accepted request causes
   task automatic encode_request(input req_type r);
      rsp_type tail;
      burst_bytes.delete();
      if (r.kind == KIND_START) begin
         crc_run = CRC_INIT;
         burst_bytes.push_back(rsp_type'{out_byte: MARK_BYTE, run_last: 1'b0, frame_end: 1'b0});
         carry_byte(BOARD_FLAG | {1'b0, r.board});
         carry_byte(r.element);
         carry_byte(r.command);
         carry_byte({1'b0, r.length[14:8]} & LEN_HI_MSK);
         carry_byte(r.length[7:0]);
         if (r.length == '0) begin
            close_frame();
         end else begin
            payload_left = r.length;
            frame_live   = 1'b1;
         end
      end else if (frame_live) begin
         carry_byte(r.data_byte);
         payload_left = payload_left - 15'd1;
         if (payload_left == '0) begin
            close_frame();
         end
      end
      if (burst_bytes.size() != 0) begin
         tail = burst_bytes.pop_back();
         tail.run_last = 1'b1;
         burst_bytes.push_back(tail);
         foreach (burst_bytes[i]) begin
            wire_bytes_due.push_back(burst_bytes[i]);
         end
      end
   endtask

   task automatic flag_mismatch(input string what, input logic [7:0] got, input logic [7:0] want);
      $display("response %0d: %s got %02h want %02h", rsp_seen, what, got, want);
      mismatch_count++;
   endtask

   // Request driver: offer the backlog with random gaps, hold while stalled
   int  send_gap   = 0;
   int  send_phase = 0;
   bit  send_calm  = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  = 0;
      end else begin
         if (req_valid && !req_stall) begin
            encode_request(req_data);
         end
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (req_backlog.size() != 0) begin
               req_valid <= 1'b1;
               req_data  <= req_backlog.pop_front();
               if (send_phase == 0) begin
                  send_phase = $urandom_range(20, 60);
                  send_calm  = ($urandom_range(0, 3) == 0);
               end
               send_phase--;
               send_gap = (send_calm || $urandom_range(0, 1) == 0) ? 0 : idle_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor and stall generator
   int  stall_left = 0;
   int  recv_phase = 0;
   bit  recv_calm  = 1'b0;
   bit  hold_done  = 1'b0;
   rsp_type want;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (wire_bytes_due.size() == 0) begin
               flag_mismatch("unexpected byte", rsp_data.out_byte, 8'h00);
            end else begin
               want = wire_bytes_due.pop_front();
               if (rsp_data.out_byte !== want.out_byte) begin
                  flag_mismatch("out_byte", rsp_data.out_byte, want.out_byte);
               end
               if (rsp_data.run_last !== want.run_last) begin
                  flag_mismatch("run_last", 8'(rsp_data.run_last), 8'(want.run_last));
               end
               if (rsp_data.frame_end !== want.frame_end) begin
                  flag_mismatch("frame_end", 8'(rsp_data.frame_end), 8'(want.frame_end));
               end
            end
            rsp_seen++;
         end
         if (recv_phase == 0) begin
            recv_phase = $urandom_range(30, 120);
            recv_calm  = ($urandom_range(0, 3) == 0);
         end
         recv_phase--;
         // Hold off once for a long stretch so the request side backs up
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (!hold_done && rsp_seen >= HOLD_OFF_AT) begin
            hold_done  = 1'b1;
            stall_left = HOLD_OFF_LEN - 1;
            rsp_stall <= 1'b1;
         end else if (!recv_calm && $urandom_range(0, 4) == 0) begin
            stall_left = idle_gap() - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog: end the run after too long with no transfer on either side
   initial begin
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("[stuffed_crc_frame_encoder_unit] ERROR");
      $finish;
   end

   // Stimulus and end of run
   initial begin
      int made;
      int pick;
      int len;
      int n;

      // Directed: stray data, zero length, escapes in header and payload,
      // abandoned frames, extreme lengths
      req_backlog.push_back(make_data(8'h55));
      req_backlog.push_back(make_start(7'h00, 8'h00, 8'h00, 15'h0000));
      req_backlog.push_back(make_start(7'h7F, 8'hFF, 8'hFF, 15'h0000));
      req_backlog.push_back(make_start(7'h40, MARK_BYTE, ESC_BYTE, 15'h0003));
      req_backlog.push_back(make_data(MARK_BYTE));
      req_backlog.push_back(make_data(ESC_BYTE));
      req_backlog.push_back(make_data(8'h00));
      req_backlog.push_back(make_data(8'hFF));
      req_backlog.push_back(make_start(7'h5B, 8'h12, 8'h34, 15'h40C0));
      req_backlog.push_back(make_data(ESC_BYTE));
      req_backlog.push_back(make_start(7'h01, ESC_BYTE, MARK_BYTE, 15'h5BDB));
      req_backlog.push_back(make_data(8'hFF));
      req_backlog.push_back(make_start(7'h2A, 8'hAA, 8'h55, 15'h7FFF));
      req_backlog.push_back(make_start(7'h7F, 8'h00, 8'h80, 15'h0001));
      req_backlog.push_back(make_data(8'hFF));
      req_backlog.push_back(make_start(7'h15, 8'h6A, 8'h01, 15'h0002));
      req_backlog.push_back(make_data(8'h00));
      req_backlog.push_back(make_data(8'h80));
      req_backlog.push_back(make_start(7'h33, 8'hC1, 8'hDA, 15'h0100));
      req_backlog.push_back(make_start(7'h0F, 8'hF0, 8'h0F, 15'h0004));
      for (int i = 0; i < 4; i++) begin
         req_backlog.push_back(make_data(wire_pick()));
      end
      req_backlog.push_back(make_data(8'hA5));

      // Random: mostly complete frames, some abandoned, some stray data
      made = 0;
      while (made < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 19);
         if (pick < 15) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
            req_backlog.push_back(make_start(7'($urandom_range(0, 127)), wire_pick(),
                                             wire_pick(), 15'(len)));
            for (int i = 0; i < len; i++) begin
               req_backlog.push_back(make_data(wire_pick()));
            end
            made += len + 1;
         end else if (pick < 18) begin
            req_backlog.push_back(make_start(7'($urandom_range(0, 127)), wire_pick(),
                                             wire_pick(), 15'($urandom_range(0, 32767))));
            n = $urandom_range(0, 3);
            for (int i = 0; i < n; i++) begin
               req_backlog.push_back(make_data(wire_pick()));
            end
            made += n + 1;
         end else begin
            req_backlog.push_back(make_data(wire_pick()));
            made += 1;
         end
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Drain: all requests taken, all bytes seen, then a short settle
      while (req_backlog.size() != 0 || req_valid) begin
         @(posedge clock);
      end
      while (wire_bytes_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && wire_bytes_due.size() == 0) begin
         $display("[stuffed_crc_frame_encoder_unit] OK");
      end else begin
         $display("[stuffed_crc_frame_encoder_unit] ERROR");
      end
      $finish;
   end

endmodule

FILE: files.f
+incdir+hdl
hdl/sfe_pkg.sv
hdl/sfe_front.sv
hdl/sfe_queue.sv
hdl/sfe_back.sv
hdl/stuffed_crc_frame_encoder_unit.sv
sim/stuffed_crc_frame_encoder_unit_tb.sv
